/* hw/rtl/lmst_pkg.sv */
// Shared types and constants for the local mean / deviation threshold block.
// Holds the controller-datapath command and status structs and register indexes.
// Depends on nothing.
package lmst_pkg;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_AW-1:0] REG_COEF   = 2'd3;

  // Number of registered stages in the threshold compare pipeline.
  localparam int CALC_CYCLES = 6;

  typedef struct packed {
    logic take;        // latch the accepted item
    logic prep;        // wrap check, line store write, set up the emission run
    logic scan_start;  // start the window scan of the current output column
    logic scan_step;   // issue one line store read
    logic load_out;    // move the threshold bit into the output register
    logic finish;      // advance the input position
  } cmd_t;

  typedef struct packed {
    logic prep_ignore; // drain item during the image rows
    logic prep_more;   // at least one result follows from this item
    logic all_issued;  // every window read has been issued
    logic scan_idle;   // all window reads have landed in the sums
    logic out_free;    // output register can take a result
    logic next_more;   // another result follows the one being loaded
  } sts_t;

endpackage

/* hw/rtl/lmst_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module lmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lmst_dp.sv */
// Datapath: configuration registers, position counters, line store, window scan,
// threshold compare pipeline and output register. Uses lmst_pkg and lmst_ram.
module lmst_dp import lmst_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic [15:0]       s_tdata,
  input  logic              s_tuser,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SLW  = $clog2(MAX_WINDOW);
  localparam int AW   = $clog2(MAX_WINDOW * MAX_WIDTH);
  localparam int NW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SW   = PIXEL_BITS + NW;
  localparam int QW   = 2 * PIXEL_BITS + NW;
  localparam int DW   = 2 * SW;
  localparam int YW   = DW + NW;
  localparam int YLW  = YW / 2;
  localparam int YHW  = YW - YLW;
  localparam int XW   = 2 * SW + NW;
  localparam int LW   = XW + 24;
  localparam int RW   = YW + 32;
  localparam int CMW  = (LW > RW) ? LW : RW;
  localparam int MAXR = (MAX_WINDOW + 1) / 2;
  localparam int RCW  = $clog2(MAXR + 1);

  // Configuration registers.
  logic [10:0]        width_reg;
  logic [15:0]        height_reg;
  logic [3:0]         win_reg;
  logic signed [15:0] coef_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd512;
      height_reg <= 16'd512;
      win_reg    <= 4'd3;
      coef_reg   <= -16'sd819;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  width_reg  <= cfg_data[10:0];
        REG_HEIGHT: height_reg <= cfg_data;
        REG_WINDOW: win_reg    <= cfg_data[3:0];
        REG_COEF:   coef_reg   <= $signed(cfg_data);
      endcase
    end
  end

  // Effective geometry after saturation.
  logic [CW:0]    w_eff;
  logic [15:0]    h_eff;
  logic [4:0]     n_sat;
  logic [4:0]     n_odd;
  logic [4:0]     n_eff;
  logic [3:0]     r_eff;
  logic [NW-1:0]  nn;

  always_comb begin
    if (width_reg == 11'd0) w_eff = (CW+1)'(1);
    else if (32'(width_reg) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width_reg);
    h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    n_sat = (32'(win_reg) > MAX_WINDOW) ? 5'(MAX_WINDOW) : {1'b0, win_reg};
    n_odd = (n_sat != 5'd0 && !n_sat[0]) ? n_sat - 5'd1 : n_sat;
    n_eff = (n_odd < 5'd3) ? 5'd3 : n_odd;
    r_eff = 4'((n_eff - 5'd1) >> 1);
    nn    = NW'(n_eff * n_eff);
  end

  // Position state and the accepted item.
  logic [15:0]           in_row;
  logic [CW-1:0]         in_col;
  logic [SLW-1:0]        in_slot;
  logic [CW:0]           oc;
  logic                  func_q;
  logic [PIXEL_BITS-1:0] pix_q;

  // Emission run set up by the prep step.
  logic           emit_q;
  logic [CW-1:0]  last_q;
  logic [15:0]    orow_q;
  logic [SLW-1:0] oslot_q;
  logic [RCW-1:0] cnt_q;
  logic           row_end_q;

  // Prep values with the frame wrap applied.
  logic           wrap;
  logic [15:0]    row_v;
  logic [CW-1:0]  col_v;
  logic [SLW-1:0] slot_v;
  logic [CW:0]    oc_v;
  logic           in_image;
  logic           row_end_v;
  logic           emit_v;
  logic [CW-1:0]  last_v;
  logic [SLW:0]   oslot_w;

  always_comb begin
    wrap      = {1'b0, in_row} >= (17'(h_eff) + 17'(r_eff));
    row_v     = wrap ? 16'd0 : in_row;
    col_v     = wrap ? '0 : in_col;
    slot_v    = wrap ? '0 : in_slot;
    oc_v      = wrap ? '0 : oc;
    in_image  = row_v < h_eff;
    row_end_v = ((CW+1)'(col_v) + (CW+1)'(1)) >= w_eff;
    emit_v    = (row_v >= 16'(r_eff)) &&
                (row_end_v || ((CW+1)'(col_v) >= (CW+1)'(r_eff)));
    last_v    = row_end_v ? CW'(w_eff - (CW+1)'(1)) : CW'(col_v - CW'(r_eff));
    if ((SLW+1)'(slot_v) >= (SLW+1)'(r_eff))
      oslot_w = (SLW+1)'(slot_v) - (SLW+1)'(r_eff);
    else
      oslot_w = (SLW+1)'(slot_v) + (SLW+1)'(MAX_WINDOW) - (SLW+1)'(r_eff);
  end

  logic [15:0]    row_inc;
  logic [SLW-1:0] slot_inc;

  always_comb begin
    row_inc  = in_row + 16'd1;
    slot_inc = (32'(in_slot) + 1 == MAX_WINDOW) ? '0 : in_slot + SLW'(1);
  end

  // Window scan state.
  logic signed [17:0]   vr;
  logic signed [CW+1:0] vc;
  logic [SLW-1:0]       slot_r;
  logic [4:0]           dr_i;
  logic [4:0]           dc_i;
  logic                 center_ph;
  logic                 all_issued;
  logic                 dv_q;
  logic                 dv_center_q;
  logic [SW-1:0]        sum_s;
  logic [QW-1:0]        sum_q;
  logic [PIXEL_BITS-1:0] p_q;

  logic signed [17:0]   vr_next;
  logic [SLW:0]         start_slot_w;
  logic [CW-1:0]        col_c;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [PIXEL_BITS-1:0] rdata;

  always_comb begin
    vr_next = vr + 18'sd1;
    if (orow_q < 16'(r_eff))
      start_slot_w = '0;
    else if ((SLW+1)'(oslot_q) >= (SLW+1)'(r_eff))
      start_slot_w = (SLW+1)'(oslot_q) - (SLW+1)'(r_eff);
    else
      start_slot_w = (SLW+1)'(oslot_q) + (SLW+1)'(MAX_WINDOW) - (SLW+1)'(r_eff);
    if (vc < 0)
      col_c = '0;
    else if (vc >= $signed({1'b0, w_eff}))
      col_c = CW'(w_eff - (CW+1)'(1));
    else
      col_c = CW'(vc);
    if (center_ph)
      raddr = AW'(oslot_q) * AW'(MAX_WIDTH) + AW'(oc[CW-1:0]);
    else
      raddr = AW'(slot_r) * AW'(MAX_WIDTH) + AW'(col_c);
    waddr = AW'(slot_v) * AW'(MAX_WIDTH) + AW'(col_v);
  end

  lmst_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WINDOW * MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.prep && in_image && !func_q),
    .waddr (waddr),
    .wdata (pix_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic next_more;
  assign next_more = ((oc + (CW+1)'(1)) <= {1'b0, last_q}) &&
                     ((32'(cnt_q) + 1) < MAXR);

  // Threshold compare pipeline, free running on the settled sums.
  logic [DW-1:0]   ss1, nq1;
  logic [SW-1:0]   np1, s1;
  logic [31:0]     k2_1, k2_2, k2_3;
  logic [DW-1:0]   d2;
  logic [SW-1:0]   a2v;
  logic            neg2, neg3, neg4, neg5;
  logic [2*SW-1:0] asq3;
  logic [YW-1:0]   y3;
  logic [XW-1:0]   x4;
  logic [YLW+31:0] ylo4;
  logic [YHW+31:0] yhi4;
  logic [CMW-1:0]  left5, right5;
  logic            res6;

  always_ff @(posedge clk) begin
    ss1  <= sum_s * sum_s;
    nq1  <= nn * sum_q;
    np1  <= nn * p_q;
    s1   <= sum_s;
    k2_1 <= 32'(coef_reg * coef_reg);
    d2   <= nq1 - ss1;
    neg2 <= np1 < s1;
    a2v  <= (np1 < s1) ? s1 - np1 : np1 - s1;
    k2_2 <= k2_1;
    asq3 <= a2v * a2v;
    y3   <= d2 * nn;
    neg3 <= neg2;
    k2_3 <= k2_2;
    x4   <= asq3 * (nn - NW'(1));
    ylo4 <= y3[YLW-1:0] * k2_3;
    yhi4 <= y3[YW-1:YLW] * k2_3;
    neg4 <= neg3;
    left5  <= CMW'(x4) << 24;
    right5 <= (CMW'(yhi4) << YLW) + CMW'(ylo4);
    neg5   <= neg4;
    if (!coef_reg[15]) res6 <= neg5 ? 1'b1 : (left5 < right5);
    else res6 <= neg5 ? (left5 > right5) : 1'b0;
  end

  // Item capture, position, run setup and scan.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_q <= s_tuser;
      pix_q  <= s_tdata[PIXEL_BITS-1:0];
    end
    if (cmd.prep) begin
      emit_q    <= emit_v;
      last_q    <= last_v;
      orow_q    <= row_v - 16'(r_eff);
      oslot_q   <= SLW'(oslot_w);
      row_end_q <= row_end_v;
    end
    if (cmd.scan_start) begin
      vr     <= $signed({2'b0, orow_q}) - $signed(18'(r_eff));
      slot_r <= SLW'(start_slot_w);
      vc     <= $signed((CW+2)'(oc)) - $signed((CW+2)'(r_eff));
      dr_i   <= '0;
      dc_i   <= '0;
      sum_s  <= '0;
      sum_q  <= '0;
    end else if (cmd.scan_step && !center_ph) begin
      if (dc_i == n_eff - 5'd1) begin
        dc_i <= '0;
        vc   <= $signed((CW+2)'(oc)) - $signed((CW+2)'(r_eff));
        dr_i <= dr_i + 5'd1;
        vr   <= vr_next;
        if (vr_next >= 18'sd1 && vr_next <= $signed({2'b0, h_eff}) - 18'sd1)
          slot_r <= (32'(slot_r) + 1 == MAX_WINDOW) ? '0 : slot_r + SLW'(1);
      end else begin
        dc_i <= dc_i + 5'd1;
        vc   <= vc + (CW+2)'(1);
      end
    end
    // Read data lands in the cycle after its address, while later reads are issued.
    if (dv_q && !dv_center_q && !cmd.scan_start) begin
      sum_s <= sum_s + SW'(rdata);
      sum_q <= sum_q + QW'(rdata * rdata);
    end
    if (dv_q && dv_center_q) begin
      p_q <= rdata;
    end
    dv_center_q <= center_ph;
    if (cmd.load_out) begin
      m_tdata <= {7'd0, res6};
      m_tlast <= !next_more;
      m_tuser <= (orow_q == h_eff - 16'd1) && (oc == w_eff - (CW+1)'(1));
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row     <= '0;
      in_col     <= '0;
      in_slot    <= '0;
      oc         <= '0;
      cnt_q      <= '0;
      center_ph  <= 1'b0;
      all_issued <= 1'b1;
      dv_q       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      dv_q <= cmd.scan_step;
      if (cmd.prep) begin
        in_row  <= row_v;
        in_col  <= col_v;
        in_slot <= slot_v;
        oc      <= oc_v;
        cnt_q   <= '0;
      end
      if (cmd.scan_start) begin
        center_ph  <= 1'b1;
        all_issued <= 1'b0;
      end else if (cmd.scan_step) begin
        if (center_ph) center_ph <= 1'b0;
        else if (dc_i == n_eff - 5'd1 && dr_i == n_eff - 5'd1) all_issued <= 1'b1;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
        oc       <= oc + (CW+1)'(1);
        cnt_q    <= cnt_q + RCW'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.finish) begin
        if (row_end_q) begin
          in_col <= '0;
          oc     <= '0;
          if ({1'b0, row_inc} >= (17'(h_eff) + 17'(r_eff))) begin
            in_row  <= '0;
            in_slot <= '0;
          end else begin
            in_row  <= row_inc;
            in_slot <= slot_inc;
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
    end
  end

  always_comb begin
    sts.prep_ignore = in_image && func_q;
    sts.prep_more   = emit_v && (oc_v <= {1'b0, last_v});
    sts.all_issued  = all_issued;
    sts.scan_idle   = all_issued && !dv_q;
    sts.out_free    = !m_tvalid || m_tready;
    sts.next_more   = emit_q && next_more;
  end

endmodule

/* hw/rtl/lmst_ctrl.sv */
// Controller state machine: sequences prep, window scan, compare wait and output.
// Uses lmst_pkg for the command and status structs.
module lmst_ctrl import lmst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_START, ST_SCAN, ST_CALC, ST_LOAD, ST_FINISH
  } state_t;

  localparam int CCW = $clog2(CALC_CYCLES);

  state_t         state;
  logic [CCW-1:0] calc_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      calc_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_PREP;
        end
        ST_PREP: begin
          if (sts.prep_ignore) state <= ST_IDLE;
          else if (sts.prep_more) state <= ST_START;
          else state <= ST_FINISH;
        end
        ST_START: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          calc_cnt <= '0;
          if (sts.scan_idle) state <= ST_CALC;
        end
        ST_CALC: begin
          calc_cnt <= calc_cnt + CCW'(1);
          if (32'(calc_cnt) == CALC_CYCLES - 1) state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (sts.out_free) state <= sts.next_more ? ST_START : ST_FINISH;
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    s_tready       = (state == ST_IDLE);
    cmd.take       = (state == ST_IDLE) && s_tvalid;
    cmd.prep       = (state == ST_PREP);
    cmd.scan_start = (state == ST_START);
    cmd.scan_step  = (state == ST_SCAN) && !sts.all_issued;
    cmd.load_out   = (state == ST_LOAD) && sts.out_free;
    cmd.finish     = (state == ST_FINISH);
  end

endmodule

/* hw/rtl/local_mean_stddev_threshold_core.sv */
// Top level of the local mean / deviation (Niblack) threshold block.
// Joins lmst_ctrl and lmst_dp; uses lmst_pkg.
//
// Usage. Pixels enter in raster order on the s_ stream: s_tdata carries the
// pixel, s_tuser is the item kind (0 image pixel, 1 drain item). After the
// last image row, radius times width drain items stand in for the rows below
// the image. Each result leaves on the m_ stream: m_tdata[0] is 1 when the
// pixel lies below mean plus k times deviation of its window, m_tlast marks
// the last result caused by one input item and m_tuser marks the result of
// the final pixel of the frame. Results lag the input by the window radius
// in rows and columns; a row end flushes the remaining columns of that row.
// Registers are written through cfg_we, cfg_addr and cfg_data while idle.
// The user must keep to this; the block does not enforce it. A new item is
// taken once the results of the last one are loaded; the pace is set by the
// single line store read port, which the scan walks one pixel per cycle.
// Reset restores the register defaults and returns to row 0, column 0; the
// line store needs no clearing. A stalled receiver holds the output register;
// the block keeps it and waits before loading the next result, and accepts
// a new item while the last result of the previous one still waits.
module local_mean_stddev_threshold_core import lmst_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // pixel
  input  logic              s_tuser,   // func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // below_threshold, then zero fill
  output logic              m_tlast,   // end_of_run
  output logic              m_tuser    // end_of_frame
);

  cmd_t cmd;
  sts_t sts;

  lmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmst_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for local_mean_stddev_threshold_core (Niblack thresholding).
// It predicts every result with its own window model and compares each result as it leaves.
// Depends on lmst_pkg and the core RTL only.
module testbench;
  import lmst_pkg::*;

  typedef struct packed {
    logic below;      // pixel below mean plus k times deviation
    logic run_end;    // last result caused by one item
    logic frame_end;  // result of the final pixel of the frame
  } result_t;

  localparam int STORE_ROWS = 15;
  localparam int STORE_COLS = 1024;
  localparam int SETTLE_CYCLES = 300;  // longer than one window scan at the largest size

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  local_mean_stddev_threshold_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor copy of the registers and of the block's position.
  logic [10:0]        reg_width;
  logic [15:0]        reg_height;
  logic [3:0]         reg_window;
  logic signed [15:0] reg_coef;
  logic [15:0]        pixel_rows [0:STORE_ROWS*STORE_COLS-1];
  int                 in_row_pos, in_col_pos, emit_col;

  result_t pending_results [$];
  int      mismatches;
  int      results_seen;
  int      items_sent;
  int      frames_run;
  bit      quiet;         // when set, neither side idles
  bit      hold_request;  // asks the receiver for one long stall
  int      hold_left;

  // Effective geometry after the block's saturation rules.
  function automatic int eff_width();
    int w;
    w = reg_width;
    if (w == 0) w = 1;
    if (w > STORE_COLS) w = STORE_COLS;
    return w;
  endfunction

  function automatic int eff_height();
    return (reg_height == 0) ? 1 : int'(reg_height);
  endfunction

  function automatic int eff_radius();
    int n;
    n = reg_window;
    if (n > STORE_ROWS) n = STORE_ROWS;
    if (n > 0 && n % 2 == 0) n--;
    if (n < 3) n = 3;
    return (n - 1) / 2;
  endfunction

  function automatic int clamp_index(int v, int limit);
    if (v < 0) return 0;
    if (v >= limit) return limit - 1;
    return v;
  endfunction

  function automatic longint unsigned stored_pixel(int row, int col);
    return pixel_rows[(row % STORE_ROWS) * STORE_COLS + (col % STORE_COLS)];
  endfunction

  // Exact Niblack decision: compares squared cross products, so no rounding enters.
  function automatic bit below_local_threshold(int orow, int ocol, int w, int h, int r);
    longint unsigned win_sum, win_sq, v, n, p, np, a, d;
    logic [127:0]    lhs, rhs, k_sq;
    bit              neg_a;
    win_sum = 0;
    win_sq = 0;
    n = (2 * r + 1) * (2 * r + 1);
    p = stored_pixel(orow, ocol);
    for (int dr = -r; dr <= r; dr++) begin
      for (int dc = -r; dc <= r; dc++) begin
        v = stored_pixel(clamp_index(orow + dr, h), clamp_index(ocol + dc, w));
        win_sum += v;
        win_sq += v * v;
      end
    end
    d = n * win_sq - win_sum * win_sum;
    np = n * p;
    neg_a = np < win_sum;
    a = neg_a ? win_sum - np : np - win_sum;
    lhs = (128'(a) * 128'(a) * 128'(n - 1)) << 24;
    k_sq = 128'(longint'(reg_coef) * longint'(reg_coef));
    rhs = 128'(d) * 128'(n) * k_sq;
    if (reg_coef >= 0) return neg_a ? 1'b1 : (lhs < rhs);
    return neg_a ? (lhs > rhs) : 1'b0;
  endfunction

  // Advances the predictor by one accepted item and queues the results it causes.
  function automatic void niblack_step(bit drain, logic [15:0] px);
    int      w, h, r, orow, last, cnt;
    bit      row_end, emit;
    result_t res;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    cnt = 0;
    emit = 0;
    last = 0;
    if (in_row_pos >= h + r) begin
      in_row_pos = 0;
      in_col_pos = 0;
      emit_col = 0;
    end
    if (in_row_pos < h) begin
      // A drain item among the image rows is dropped without effect.
      if (drain) return;
      pixel_rows[(in_row_pos % STORE_ROWS) * STORE_COLS + (in_col_pos % STORE_COLS)] = px;
    end
    row_end = in_col_pos + 1 >= w;
    if (in_row_pos >= r) begin
      orow = in_row_pos - r;
      if (row_end) begin
        last = w - 1;
        emit = 1;
      end else if (in_col_pos >= r) begin
        last = in_col_pos - r;
        emit = 1;
      end
      while (emit && emit_col <= last && cnt < (STORE_ROWS + 1) / 2) begin
        res.below = below_local_threshold(orow, emit_col, w, h, r);
        res.run_end = 1'b0;
        res.frame_end = (orow == h - 1) && (emit_col == w - 1);
        pending_results.push_back(res);
        emit_col++;
        cnt++;
      end
      if (cnt > 0) pending_results[pending_results.size() - 1].run_end = 1'b1;
    end
    if (row_end) begin
      in_col_pos = 0;
      emit_col = 0;
      in_row_pos++;
      if (in_row_pos >= h + r) in_row_pos = 0;
    end else begin
      in_col_pos++;
    end
  endfunction

  task automatic report_mismatch(string field, int expected, int got);
    mismatches++;
    $display("MISMATCH at %0t: %s expected %0d got %0d", $time, field, expected, got);
  endtask

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== {7'd0, want.below}) report_mismatch("below_threshold", want.below, m_tdata);
        if (m_tlast !== want.run_end) report_mismatch("end_of_run", want.run_end, m_tlast);
        if (m_tuser !== want.frame_end) report_mismatch("end_of_frame", want.frame_end, m_tuser);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 35);
    end
  end

  // Sends one item; entered and left at a falling edge.
  task automatic send_item(bit drain, logic [15:0] px);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= drain;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    niblack_step(drain, px);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  reg_width = value[10:0];
      REG_HEIGHT: reg_height = value;
      REG_WINDOW: reg_window = value[3:0];
      REG_COEF:   reg_coef = value;
      default: ;
    endcase
  endtask

  // Waits until every prediction is met and items without results have drained.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Runs one whole frame. With noise, stray drain items fall among the image
  // rows, pixel items among the drain rows, and an extra drain item follows.
  task automatic run_frame(logic [10:0] w_raw, logic [15:0] h_raw, logic [3:0] win_raw,
                           logic [15:0] coef, bit noise);
    int w, h, r;
    wait_idle();
    write_reg(REG_WIDTH, 16'(w_raw));
    write_reg(REG_HEIGHT, h_raw);
    write_reg(REG_WINDOW, 16'(win_raw));
    write_reg(REG_COEF, coef);
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_item(1'b1, 16'($urandom));
      send_item(1'b0, pick_pixel());
    end
    for (int i = 0; i < w * r; i++)
      send_item(noise ? ($urandom_range(0, 4) != 0) : 1'b1, 16'($urandom));
    if (noise) send_item(1'b1, 16'($urandom));
    frames_run++;
  endtask

  // Zero size registers act as one, a window below three acts as three.
  task automatic test_degenerate_sizes();
    run_frame(11'd0, 16'd0, 4'd0, 16'd0, 1'b1);
    run_frame(11'd1, 16'd1, 4'd1, 16'h7FFF, 1'b0);
    run_frame(11'd2, 16'd2, 4'd2, 16'h8000, 1'b1);
  endtask

  // Largest window (radius beyond the image) and an even window size.
  task automatic test_window_extremes();
    run_frame(11'd3, 16'd2, 4'd15, 16'hFCCD, 1'b0);
    run_frame(11'd4, 16'd3, 4'd4, 16'd4096, 1'b0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    wait_idle();
    hold_request = 1'b1;
    run_frame(11'd12, 16'd3, 4'd5, 16'h0800, 1'b0);
  endtask

  // Random well-formed frames with some noise, mostly small windows; the
  // widest window with a row wide enough to emit a full run of results.
  task automatic test_random_frames();
    int start;
    start = items_sent;
    run_frame(11'd9, 16'd1, 4'd15, 16'($urandom), 1'b0);
    while (items_sent - start < 100) begin
      quiet = ($urandom_range(0, 5) == 0);
      run_frame(11'($urandom_range(1, 10)), 16'($urandom_range(1, 6)),
                4'($urandom_range(0, 15) > 12 ? $urandom_range(0, 15) : $urandom_range(3, 7)),
                16'($urandom), $urandom_range(0, 2) == 0);
    end
    quiet = 1'b0;
  endtask

  // A row wider than any window; the largest height is written and replaced.
  task automatic test_wide_row();
    wait_idle();
    write_reg(REG_HEIGHT, 16'hFFFF);
    run_frame(11'd16, 16'd1, 4'd3, 16'hFCCD, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    reg_width = 11'd512;
    reg_height = 16'd512;
    reg_window = 4'd3;
    reg_coef = -16'sd819;
    in_row_pos = 0;
    in_col_pos = 0;
    emit_col = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    frames_run = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_degenerate_sizes();
    test_window_extremes();
    test_backpressure();
    test_random_frames();
    test_wide_row();
    wait_idle();

    $display("Ran %0d frames: %0d items in, %0d results checked, windows 3 to 15,",
             frames_run, items_sent, results_seen);
    $display("with stray drain and pixel items, random stalls and one long hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
